### rtl/huffman_code_bit_packer_defines.svh
// Assertion macros for the Huffman code bit packer.
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled in reset.
`define HCBP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcbp check failed");

// Next-cycle implication, disabled in reset.
`define HCBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcbp check failed");

`else

`define HCBP_ASSERT_NOW(label, clk, rst, ante, cons)
`define HCBP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int ENTRY_W = CODE_W + LEN_W;
  localparam int SR_W    = CODE_W + BYTE_W;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ENCODE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_t;

endpackage

### rtl/hcbp_if.sv
// Valid/ready channel interfaces for command words and packed output words.
`timescale 1ns / 1ps

interface hcbp_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  symbol;
  logic [31:0] code_bits;
  logic [5:0]  code_length;

  modport source (output valid, func, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, func, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] pad_bits;
  logic       is_final;
  logic       last;

  modport source (output valid, out_byte, pad_bits, is_final, last, input ready);
  modport sink   (input valid, out_byte, pad_bits, is_final, last, output ready);
endinterface

### rtl/hcbp_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: code table RAM, packer and control.
`timescale 1ns / 1ps
//
// Each command word is a load, an encode or a flush. A load writes one code table entry.
// An encode reads the table RAM, merges the code with the pending bits, and then gives
// the n (0 to 4) packed bytes it completes, one output word per cycle while the sink is
// ready. A flush with pending bits gives one padded word; with nothing pending it gives
// no word. The code table lives in one single-port RAM with a registered read; a load
// followed directly by an encode of the same symbol sees the new entry. Table entries
// read before they are written hold arbitrary values.
`include "huffman_code_bit_packer_defines.svh"

module huffman_code_bit_packer #(
  parameter int MAX_CODE_BITS = 32,
  parameter int SYMBOL_COUNT  = 256
) (
  input logic       clk,
  input logic       rst,
  hcbp_cmd_if.sink  cmd,
  hcbp_res_if.source res
);

  localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
  localparam int LEN_LIM = (MAX_CODE_BITS < hcbp_pkg::CODE_W) ? MAX_CODE_BITS
                                                              : hcbp_pkg::CODE_W;
  localparam logic [hcbp_pkg::LEN_W-1:0] LEN_MAX = hcbp_pkg::LEN_W'(LEN_LIM);
  localparam logic [8:0] SYM_LIM = 9'(SYMBOL_COUNT);

  hcbp_pkg::state_t state, state_next;

  // Packer state: pending bits left aligned, zeros below them.
  logic [7:0] partial_hi;
  logic [2:0] pending;

  logic [hcbp_pkg::SR_W-1:0] sr;
  logic [2:0]                cnt;
  logic [2:0]                rem;
  logic [2:0]                pad;
  logic                      is_final;

  logic cmd_fire, res_fire, sym_ok;
  logic ram_we;
  logic [hcbp_pkg::LEN_W-1:0]   ld_len;
  logic [hcbp_pkg::ENTRY_W-1:0] ram_rdata;
  logic [hcbp_pkg::CODE_W-1:0]  rd_code, code_rev, code_mask;
  logic [hcbp_pkg::LEN_W-1:0]   rd_len, total;
  logic [hcbp_pkg::SR_W-1:0]    stream;

  assign cmd_fire = cmd.valid && cmd.ready;
  assign res_fire = res.valid && res.ready;
  assign sym_ok   = {1'b0, cmd.symbol} < SYM_LIM;
  assign ld_len   = (cmd.code_length > LEN_MAX) ? LEN_MAX : cmd.code_length;
  assign ram_we   = cmd_fire && (cmd.func == hcbp_pkg::FUNC_LOAD) && sym_ok;

  hcbp_ram #(
    .WIDTH (hcbp_pkg::ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (cmd.symbol[ADDR_W-1:0]),
    .wdata ({ld_len, cmd.code_bits}),
    .rdata (ram_rdata)
  );

  // Merge the looked-up code behind the pending bits, first code bit at the top.
  always_comb begin
    rd_code = ram_rdata[hcbp_pkg::CODE_W-1:0];
    rd_len  = ram_rdata[hcbp_pkg::ENTRY_W-1:hcbp_pkg::CODE_W];
    for (int i = 0; i < hcbp_pkg::CODE_W; i++) begin
      code_rev[hcbp_pkg::CODE_W-1-i] = rd_code[i];
    end
    code_mask = ~({hcbp_pkg::CODE_W{1'b1}} >> rd_len);
    stream    = {partial_hi, {hcbp_pkg::CODE_W{1'b0}}}
              | ({code_rev & code_mask, 8'b0} >> pending);
    total     = hcbp_pkg::LEN_W'(pending) + rd_len;
  end

  always_comb begin
    state_next = state;
    case (state)
      hcbp_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          if (cmd.func == hcbp_pkg::FUNC_ENCODE && sym_ok) begin
            state_next = hcbp_pkg::ST_LOOKUP;
          end else if (cmd.func == hcbp_pkg::FUNC_FLUSH && pending != 3'd0) begin
            state_next = hcbp_pkg::ST_EMIT;
          end
        end
      end
      hcbp_pkg::ST_LOOKUP: begin
        state_next = (total[5:3] != 3'd0) ? hcbp_pkg::ST_EMIT : hcbp_pkg::ST_IDLE;
      end
      hcbp_pkg::ST_EMIT: begin
        if (res_fire && cnt == 3'd1) begin
          state_next = hcbp_pkg::ST_IDLE;
        end
      end
      default: state_next = hcbp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready    = (state == hcbp_pkg::ST_IDLE);
    res.valid    = (state == hcbp_pkg::ST_EMIT);
    res.out_byte = sr[hcbp_pkg::SR_W-1 -: 8];
    res.pad_bits = pad;
    res.is_final = is_final;
    res.last     = (cnt == 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hcbp_pkg::ST_IDLE;
      partial_hi <= 8'd0;
      pending    <= 3'd0;
      cnt        <= 3'd0;
    end else begin
      state <= state_next;
      case (state)
        hcbp_pkg::ST_IDLE: begin
          if (cmd_fire && cmd.func == hcbp_pkg::FUNC_FLUSH && pending != 3'd0) begin
            sr       <= {partial_hi, {hcbp_pkg::CODE_W{1'b0}}};
            cnt      <= 3'd1;
            rem      <= 3'd0;
            is_final <= 1'b1;
            pad      <= 3'(4'd8 - {1'b0, pending});
          end else if (cmd_fire && cmd.func == hcbp_pkg::FUNC_ENCODE) begin
            is_final <= 1'b0;
            pad      <= 3'd0;
          end
        end
        hcbp_pkg::ST_LOOKUP: begin
          sr  <= stream;
          cnt <= total[5:3];
          rem <= total[2:0];
          // No full byte: keep the merged bits as the new partial byte.
          if (total[5:3] == 3'd0) begin
            partial_hi <= stream[hcbp_pkg::SR_W-1 -: 8];
            pending    <= total[2:0];
          end
        end
        hcbp_pkg::ST_EMIT: begin
          if (res_fire) begin
            sr  <= sr << 8;
            cnt <= cnt - 3'd1;
            if (cnt == 3'd1) begin
              partial_hi <= sr[hcbp_pkg::SR_W-9 -: 8];
              pending    <= rem;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `HCBP_ASSERT_NOW(a_no_overlap, clk, rst, cmd.ready, !res.valid)
  `HCBP_ASSERT_NOW(a_emit_count, clk, rst, state == hcbp_pkg::ST_EMIT,
                   cnt != 3'd0 && cnt <= 3'd4)
  `HCBP_ASSERT_NOW(a_partial_clean, clk, rst, state == hcbp_pkg::ST_IDLE,
                   (partial_hi & (8'hFF >> pending)) == 8'd0)
  `HCBP_ASSERT_NEXT(a_encode_lookup, clk, rst,
                    cmd_fire && cmd.func == hcbp_pkg::FUNC_ENCODE && sym_ok,
                    state == hcbp_pkg::ST_LOOKUP)

endmodule
